@@ hdl/sepp_pkg.sv @@
`default_nettype none

package sepp_pkg;

   // default geometry
   localparam int SEPP_SAMPLE_WIDTH     = 24;
   localparam int SEPP_SINE_TABLE_DEPTH = 256;

   // fixed field widths
   localparam int MODE_WIDTH      = 2;
   localparam int PAN_WIDTH       = 16;
   localparam int PAN_FRAC_EXTRA  = 16;
   localparam int PAN_WIDE_WIDTH  = PAN_WIDTH + PAN_FRAC_EXTRA;
   localparam int RAMP_WIDTH      = 16;
   localparam int GAIN_WIDTH      = 16;
   localparam int GAIN_FRAC       = 15;
   localparam int FRAC_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = RAMP_WIDTH;

   // ramp divider
   localparam int DIV_DIVIDEND_WIDTH = PAN_WIDE_WIDTH + 1;
   localparam int DIV_COUNT_WIDTH    = $clog2(DIV_DIVIDEND_WIDTH + 1);

   localparam logic [RAMP_WIDTH-1:0]     RAMP_STEPS_RESET = 16'd2205;
   localparam logic [PAN_WIDE_WIDTH-1:0] PAN_WIDE_MAX     = 32'h7FFF_FFFF;
   localparam logic [PAN_WIDE_WIDTH-1:0] PAN_WIDE_MIN     = 32'h8000_0000;

   // pi in Q2.30
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_SNAP   = 2'd1,
      MODE_HOLD   = 2'd2
   } sepp_mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RAMP_STEPS = 1'b0,
      CSR_ENABLED    = 1'b1
   } sepp_csr_type;

   typedef struct packed {
      logic capture;
      logic snap;
      logic hold;
      logic retarget;
      logic load_step;
      logic advance;
      logic look;
      logic look_right;
      logic interp;
      logic mul_left;
      logic push;
   } sepp_cmd_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic                  enabled;
      logic                  differs;
      logic                  ramp_zero;
      logic                  div_done;
      logic                  out_free;
   } sepp_status_type;

   // one quarter-wave table entry from its angle in Q2.30, taylor series
   function automatic logic [GAIN_WIDTH-1:0] sepp_sine_entry_f(input logic [63:0] x);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] r;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            sum = (sum > term) ? (sum - term) : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[GAIN_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/smoothed_equal_power_pan_top.sv @@
`default_nettype none

// smoothed equal-power stereo panner. each request carries a signed stereo pair, a
// Q1.15 pan target and a mode (sample, snap, hold). the pan moves toward the target
// on a linear ramp of ramp_steps samples, and the pair leaves scaled by cos/sin of
// (pan+1)*pi/4, taken from an interpolated quarter-wave sine table and rounded.
// snap and hold act on the ramp even when disabled and never give a response;
// a sample request while disabled is dropped. a sample request goes through decode,
// ramp step, left and right lookup, left multiply and push, and no new request is
// taken until the push; the push waits while the output register is held. a request
// whose target differs from the current goal also waits, while ramp_steps is nonzero,
// for the bit-serial divider that works out the ramp step (one quotient bit a cycle
// over 33 bits). snap, hold, disabled or unused-mode requests end after decode.
// the left and right gains share one table lookup, interpolator and multiplier in a
// short pipeline. a finished response sits in an output register, so the next
// request is taken while it waits. config writes are taken every cycle
// (csr_ready is tied high); index 0 is ramp_steps, index 1 is enabled.
module smoothed_equal_power_pan_top import sepp_pkg::*; #(
   parameter int SAMPLE_WIDTH     = SEPP_SAMPLE_WIDTH,
   parameter int SINE_TABLE_DEPTH = SEPP_SINE_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,

   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [MODE_WIDTH-1:0]          req_mode,
   input  logic signed [SAMPLE_WIDTH-1:0] req_left_in,
   input  logic signed [SAMPLE_WIDTH-1:0] req_right_in,
   input  logic signed [PAN_WIDTH-1:0]    req_pan_target,

   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_right_out,

   // register write port
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_data
);

   sepp_cmd_type    cmd;
   sepp_status_type status;

   // registers are plain flops, always able to take a write
   assign csr_ready = 1'b1;

   // sequencer: decode, divide wait, ramp step, gain pipeline, response push
   sepp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // ramp state, divider, sine table, shared multiplier and response register
   sepp_dp #(
      .SAMPLE_WIDTH     (SAMPLE_WIDTH),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_write      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_mode       (req_mode),
      .req_left_in    (req_left_in),
      .req_right_in   (req_right_in),
      .req_pan_target (req_pan_target),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_left_out   (rsp_left_out),
      .rsp_right_out  (rsp_right_out)
   );

endmodule

`default_nettype wire

@@ hdl/sepp_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle
module sepp_div import sepp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIV_DIVIDEND_WIDTH-1:0] dividend,
   input  logic                          negative,
   input  logic [RAMP_WIDTH-1:0]         divisor,
   output logic                          done,
   output logic [DIV_DIVIDEND_WIDTH-1:0] quotient,
   output logic                          quotient_neg
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [DIV_COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [DIV_DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [RAMP_WIDTH-1:0]         rem_ff, rem_in;
   logic [RAMP_WIDTH-1:0]         divisor_ff, divisor_in;
   logic                          neg_ff, neg_in;

   logic [RAMP_WIDTH:0] trial;
   logic [RAMP_WIDTH:0] trial_sub;
   logic                fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_DIVIDEND_WIDTH-1]};
      trial_sub = trial - {1'b0, divisor_ff};
      fits      = (trial >= {1'b0, divisor_ff});
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = DIV_COUNT_WIDTH'(DIV_DIVIDEND_WIDTH);
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         neg_in     = negative;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIV_DIVIDEND_WIDTH-2:0], fits};
         rem_in   = fits ? trial_sub[RAMP_WIDTH-1:0] : trial[RAMP_WIDTH-1:0];
         count_in = count_ff - DIV_COUNT_WIDTH'(1);
         if (count_ff == DIV_COUNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
   end

   assign done         = done_ff;
   assign quotient     = quo_ff;
   assign quotient_neg = neg_ff;

endmodule

`default_nettype wire

@@ hdl/sepp_dp.sv @@
`default_nettype none

module sepp_dp import sepp_pkg::*; #(
   parameter int SAMPLE_WIDTH     = SEPP_SAMPLE_WIDTH,
   parameter int SINE_TABLE_DEPTH = SEPP_SINE_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sepp_cmd_type                   cmd,
   output sepp_status_type                status,
   input  logic                           csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_data,
   input  logic [MODE_WIDTH-1:0]          req_mode,
   input  logic signed [SAMPLE_WIDTH-1:0] req_left_in,
   input  logic signed [SAMPLE_WIDTH-1:0] req_right_in,
   input  logic signed [PAN_WIDTH-1:0]    req_pan_target,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_right_out
);

   localparam int IdxWidth = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PosWidth = PAN_WIDE_WIDTH + 1;
   localparam int PosProdWidth = PAN_WIDE_WIDTH + IdxWidth;
   localparam int MulWidth = SAMPLE_WIDTH + GAIN_WIDTH + 1;

   // quarter-wave sine table, entries 0..depth
   logic [GAIN_WIDTH-1:0] sine_tab [SINE_TABLE_DEPTH+1];

   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
      localparam logic [63:0] AngleQ30 = (PI_Q30 * 64'(k)) / 64'(2 * SINE_TABLE_DEPTH);
      assign sine_tab[k] = sepp_sine_entry_f(AngleQ30);
   end

   // configuration
   logic [RAMP_WIDTH-1:0] ramp_steps_ff, ramp_steps_in;
   logic                  enabled_ff, enabled_in;

   // captured request
   logic [MODE_WIDTH-1:0]          mode_ff, mode_in;
   logic signed [SAMPLE_WIDTH-1:0] left_ff, left_in;
   logic signed [SAMPLE_WIDTH-1:0] right_ff, right_in;
   logic [PAN_WIDTH-1:0]           target_ff, target_in;

   // ramp state
   logic [PAN_WIDE_WIDTH-1:0] pan_current_ff, pan_current_in;
   logic [PAN_WIDTH-1:0]      pan_goal_ff, pan_goal_in;
   logic [PAN_WIDE_WIDTH-1:0] pan_step_ff, pan_step_in;
   logic [RAMP_WIDTH-1:0]     steps_left_ff, steps_left_in;

   // gain pipeline
   logic [GAIN_WIDTH-1:0]          tab_a_ff, tab_a_in;
   logic [GAIN_WIDTH-1:0]          tab_d_ff, tab_d_in;
   logic [FRAC_WIDTH-1:0]          frac_ff, frac_in;
   logic [GAIN_WIDTH-1:0]          gain_ff, gain_in;
   logic signed [SAMPLE_WIDTH-1:0] res_l_ff, res_l_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_right_ff, rsp_right_in;

   // divider hookup
   logic                          div_start;
   logic                          div_done;
   logic [DIV_DIVIDEND_WIDTH-1:0] div_quo;
   logic                          div_neg;
   logic [DIV_DIVIDEND_WIDTH-1:0] diff;
   logic [DIV_DIVIDEND_WIDTH-1:0] diff_mag;

   logic [PAN_WIDE_WIDTH-1:0] goal_wide;
   logic [PAN_WIDE_WIDTH-1:0] target_wide;
   logic [PAN_WIDE_WIDTH:0]   ramp_sum;
   logic [PAN_WIDE_WIDTH-1:0] ramp_sat;
   logic [RAMP_WIDTH-1:0]     steps_dec;
   logic [PAN_WIDE_WIDTH-1:0] step_clamped;
   logic                      out_free;

   logic [PAN_WIDE_WIDTH-1:0] pos_u;
   logic [PosWidth-1:0]       pos;
   logic [PosProdWidth-1:0]   pos_prod;
   logic [IdxWidth-1:0]       idx;
   logic [IdxWidth-1:0]       idx_next;
   logic [31:0]               interp_prod;
   logic [31:0]               interp_sum;

   logic signed [SAMPLE_WIDTH-1:0] mul_x;
   logic signed [MulWidth-1:0]     mul_prod;
   logic signed [MulWidth-1:0]     mul_rnd;
   logic signed [SAMPLE_WIDTH-1:0] mul_res;

   assign goal_wide   = {pan_goal_ff, {PAN_FRAC_EXTRA{1'b0}}};
   assign target_wide = {target_ff, {PAN_FRAC_EXTRA{1'b0}}};
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // signed distance from the current pan to the new target
   always_comb begin
      diff     = {target_wide[PAN_WIDE_WIDTH-1], target_wide}
               - {pan_current_ff[PAN_WIDE_WIDTH-1], pan_current_ff};
      diff_mag = diff[DIV_DIVIDEND_WIDTH-1] ? (DIV_DIVIDEND_WIDTH'(0) - diff) : diff;
   end

   assign div_start = cmd.retarget && (ramp_steps_ff != '0);

   sepp_div u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (div_start),
      .dividend     (diff_mag),
      .negative     (diff[DIV_DIVIDEND_WIDTH-1]),
      .divisor      (ramp_steps_ff),
      .done         (div_done),
      .quotient     (div_quo),
      .quotient_neg (div_neg)
   );

   // saturate the quotient into the signed 32-bit step
   always_comb begin
      if (div_neg) begin
         if (div_quo[PAN_WIDE_WIDTH] ||
             (div_quo[PAN_WIDE_WIDTH-1] && (|div_quo[PAN_WIDE_WIDTH-2:0]))) begin
            step_clamped = PAN_WIDE_MIN;
         end else begin
            step_clamped = PAN_WIDE_WIDTH'(0) - div_quo[PAN_WIDE_WIDTH-1:0];
         end
      end else if (div_quo[PAN_WIDE_WIDTH] || div_quo[PAN_WIDE_WIDTH-1]) begin
         step_clamped = PAN_WIDE_MAX;
      end else begin
         step_clamped = div_quo[PAN_WIDE_WIDTH-1:0];
      end
   end

   // one ramp step, saturating
   always_comb begin
      steps_dec = steps_left_ff - RAMP_WIDTH'(1);
      ramp_sum  = {pan_current_ff[PAN_WIDE_WIDTH-1], pan_current_ff}
                + {pan_step_ff[PAN_WIDE_WIDTH-1], pan_step_ff};
      if (ramp_sum[PAN_WIDE_WIDTH] != ramp_sum[PAN_WIDE_WIDTH-1]) begin
         ramp_sat = ramp_sum[PAN_WIDE_WIDTH] ? PAN_WIDE_MIN : PAN_WIDE_MAX;
      end else begin
         ramp_sat = ramp_sum[PAN_WIDE_WIDTH-1:0];
      end
   end

   always_comb begin
      pan_current_in = pan_current_ff;
      pan_goal_in    = pan_goal_ff;
      pan_step_in    = pan_step_ff;
      steps_left_in  = steps_left_ff;
      if (cmd.snap) begin
         pan_goal_in    = target_ff;
         pan_current_in = target_wide;
         steps_left_in  = '0;
      end else if (cmd.hold) begin
         // floor to Q1.15
         pan_goal_in    = pan_current_ff[PAN_WIDE_WIDTH-1:PAN_FRAC_EXTRA];
         pan_current_in = {pan_current_ff[PAN_WIDE_WIDTH-1:PAN_FRAC_EXTRA],
                           {PAN_FRAC_EXTRA{1'b0}}};
         steps_left_in  = '0;
      end else if (cmd.retarget) begin
         pan_goal_in = target_ff;
         if (ramp_steps_ff == '0) begin
            pan_current_in = target_wide;
            steps_left_in  = '0;
         end else begin
            steps_left_in = ramp_steps_ff;
         end
      end else if (cmd.load_step) begin
         pan_step_in = step_clamped;
      end else if (cmd.advance) begin
         if (steps_left_ff != '0) begin
            steps_left_in  = steps_dec;
            pan_current_in = (steps_dec != '0) ? ramp_sat : goal_wide;
         end else begin
            pan_current_in = goal_wide;
         end
      end
   end

   // table lookup: position along the quarter wave, left uses the mirror
   always_comb begin
      pos_u    = {~pan_current_ff[PAN_WIDE_WIDTH-1], pan_current_ff[PAN_WIDE_WIDTH-2:0]};
      pos      = cmd.look_right ? {1'b0, pos_u}
                                : ({1'b1, {PAN_WIDE_WIDTH{1'b0}}} - {1'b0, pos_u});
      pos_prod = PosProdWidth'(pos) * PosProdWidth'(SINE_TABLE_DEPTH);
      idx      = pos_prod[PosProdWidth-1:PAN_WIDE_WIDTH];
      idx_next = idx + IdxWidth'(1);
      frac_in  = pos_prod[PAN_WIDE_WIDTH-1:PAN_WIDE_WIDTH-FRAC_WIDTH];
      if (idx >= IdxWidth'(SINE_TABLE_DEPTH)) begin
         tab_a_in = sine_tab[IdxWidth'(SINE_TABLE_DEPTH)];
         tab_d_in = '0;
      end else begin
         tab_a_in = sine_tab[idx];
         tab_d_in = sine_tab[idx_next] - sine_tab[idx];
      end
   end

   // linear interpolation between neighbors
   always_comb begin
      interp_prod = 32'(tab_d_ff) * 32'(frac_ff);
      interp_sum  = interp_prod + 32'd32768;
      gain_in     = tab_a_ff + interp_sum[31:16];
   end

   // sample times gain, rounded half up
   always_comb begin
      mul_x    = cmd.push ? right_ff : left_ff;
      mul_prod = MulWidth'(mul_x) * MulWidth'($signed({1'b0, gain_ff}));
      mul_rnd  = mul_prod + MulWidth'(16384);
      mul_res  = mul_rnd[SAMPLE_WIDTH+GAIN_FRAC-1:GAIN_FRAC];
      res_l_in = cmd.mul_left ? mul_res : res_l_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
         rsp_left_in  = res_l_ff;
         rsp_right_in = mul_res;
      end
   end

   always_comb begin
      ramp_steps_in = ramp_steps_ff;
      enabled_in    = enabled_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RAMP_STEPS: ramp_steps_in = csr_data;
            CSR_ENABLED:    enabled_in    = csr_data[0];
         endcase
      end
   end

   always_comb begin
      mode_in   = cmd.capture ? req_mode       : mode_ff;
      left_in   = cmd.capture ? req_left_in    : left_ff;
      right_in  = cmd.capture ? req_right_in   : right_ff;
      target_in = cmd.capture ? req_pan_target : target_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_steps_ff  <= RAMP_STEPS_RESET;
         enabled_ff     <= 1'b1;
         pan_current_ff <= '0;
         pan_goal_ff    <= '0;
         pan_step_ff    <= '0;
         steps_left_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ramp_steps_ff  <= ramp_steps_in;
         enabled_ff     <= enabled_in;
         pan_current_ff <= pan_current_in;
         pan_goal_ff    <= pan_goal_in;
         pan_step_ff    <= pan_step_in;
         steps_left_ff  <= steps_left_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      target_ff    <= target_in;
      if (cmd.look) begin
         tab_a_ff <= tab_a_in;
         tab_d_ff <= tab_d_in;
         frac_ff  <= frac_in;
      end
      if (cmd.interp) begin
         gain_ff <= gain_in;
      end
      res_l_ff     <= res_l_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   always_comb begin
      status.mode      = mode_ff;
      status.enabled   = enabled_ff;
      status.differs   = (target_ff != pan_goal_ff);
      status.ramp_zero = (ramp_steps_ff == '0);
      status.div_done  = div_done;
      status.out_free  = out_free;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   a_snap_lands: assert property (@(posedge clock) disable iff (reset)
      cmd.snap |=> (pan_current_ff[PAN_FRAC_EXTRA-1:0] == '0) && (steps_left_ff == '0))
      else $error("snap did not land on a Q1.15 pan with the ramp stopped");

   a_hold_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.hold |=> pan_goal_ff == $past(pan_current_ff[PAN_WIDE_WIDTH-1:PAN_FRAC_EXTRA]))
      else $error("hold goal is not the floored current pan");

   a_ramp_end: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |=> (steps_left_ff != '0) || (pan_current_ff == goal_wide))
      else $error("finished ramp left the pan off its goal");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> out_free)
      else $error("result pushed over an unaccepted response");

endmodule

`default_nettype wire

@@ hdl/sepp_ctrl.sv @@
`default_nettype none

module sepp_ctrl import sepp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  sepp_status_type status,
   output sepp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_DIV,
      S_ADV,
      S_LOOK_L,
      S_LOOK_R,
      S_MUL_L,
      S_PUSH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            unique case (status.mode)
               MODE_SNAP: begin
                  cmd.snap = 1'b1;
                  state_in = S_IDLE;
               end
               MODE_HOLD: begin
                  cmd.hold = 1'b1;
                  state_in = S_IDLE;
               end
               MODE_SAMPLE: begin
                  if (!status.enabled) begin
                     state_in = S_IDLE;
                  end else if (status.differs) begin
                     cmd.retarget = 1'b1;
                     state_in     = status.ramp_zero ? S_ADV : S_DIV;
                  end else begin
                     state_in = S_ADV;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.load_step = 1'b1;
               state_in      = S_ADV;
            end
         end
         S_ADV: begin
            cmd.advance = 1'b1;
            state_in    = S_LOOK_L;
         end
         S_LOOK_L: begin
            cmd.look = 1'b1;
            state_in = S_LOOK_R;
         end
         S_LOOK_R: begin
            cmd.look       = 1'b1;
            cmd.look_right = 1'b1;
            cmd.interp     = 1'b1;
            state_in       = S_MUL_L;
         end
         S_MUL_L: begin
            cmd.interp   = 1'b1;
            cmd.mul_left = 1'b1;
            state_in     = S_PUSH;
         end
         S_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

@@ dv/sepp_pan_checker.sv @@
`default_nettype none

module sepp_pan_checker import sepp_pkg::*; (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [MODE_WIDTH-1:0]               req_mode,
   input  logic signed [SEPP_SAMPLE_WIDTH-1:0] req_left_in,
   input  logic signed [SEPP_SAMPLE_WIDTH-1:0] req_right_in,
   input  logic signed [PAN_WIDTH-1:0]         req_pan_target,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [SEPP_SAMPLE_WIDTH-1:0] rsp_left_out,
   input  logic signed [SEPP_SAMPLE_WIDTH-1:0] rsp_right_out,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]          csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]           csr_data,
   output int unsigned                         fail_count,
   output int unsigned                         pending_count,
   output int unsigned                         checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW    = SEPP_SAMPLE_WIDTH;
   localparam int DEPTH = SEPP_SINE_TABLE_DEPTH;
   localparam longint unsigned FULL_TURN = 64'h1_0000_0000;

   typedef struct {
      logic signed [SW-1:0] left_out;
      logic signed [SW-1:0] right_out;
   } pan_pair_type;

   pan_pair_type expected_pairs[$];

   logic [GAIN_WIDTH-1:0]            sine_lut [0:DEPTH];
   logic [RAMP_WIDTH-1:0]            ramp_len;
   logic                             enable_flag;
   logic signed [PAN_WIDE_WIDTH-1:0] pan_now;
   logic signed [PAN_WIDE_WIDTH-1:0] pan_inc;
   logic signed [PAN_WIDTH-1:0]      pan_goal;
   logic [RAMP_WIDTH-1:0]            steps_remaining;
   int unsigned                      fails  = 0;
   int unsigned                      checks = 0;

   // taylor series of sin over odd powers, angle in Q2.30
   function automatic logic [GAIN_WIDTH-1:0] quarter_sine(int unsigned k);
      longint unsigned angle;
      longint unsigned power;
      longint unsigned series;
      longint unsigned q15;
      angle  = (PI_Q30 * k) / (2 * DEPTH);
      power  = angle;
      series = angle;
      for (int n = 1; n <= 8; n++) begin
         power = (((power * angle) >> 30) * angle) >> 30;
         power = power / longint'(2 * n * (2 * n + 1));
         if ((n % 2) == 1) begin
            series = (series > power) ? series - power : 64'd0;
         end else begin
            series = series + power;
         end
      end
      q15 = (series + 64'd16384) >> 15;
      if (q15 > 64'd32767) begin
         q15 = 64'd32767;
      end
      return q15[GAIN_WIDTH-1:0];
   endfunction

   // interpolated lookup, pos is a fraction of a quarter turn in Q0.32
   function automatic longint unsigned gain_lookup(longint unsigned pos);
      longint unsigned scaled;
      longint unsigned idx;
      longint unsigned frac;
      longint unsigned lo;
      longint unsigned hi;
      scaled = pos * DEPTH;
      idx    = scaled >> 32;
      frac   = (scaled >> 16) & 64'hFFFF;
      if (idx >= DEPTH) begin
         return sine_lut[DEPTH];
      end
      lo = sine_lut[idx];
      hi = sine_lut[idx + 1];
      return lo + (((hi - lo) * frac + 64'd32768) >> 16);
   endfunction

   // rounded product, floor after adding half an lsb
   function automatic logic signed [SW-1:0] apply_gain(logic signed [SW-1:0] value,
                                                       longint unsigned gain);
      longint signed acc;
      acc = longint'(value) * longint'(gain) + 64'sd16384;
      acc = acc >>> GAIN_FRAC;
      return acc[SW-1:0];
   endfunction

   function automatic logic signed [PAN_WIDE_WIDTH-1:0] clamp_wide(longint signed v);
      if (v > 64'sd2147483647) begin
         return PAN_WIDE_MAX;
      end
      if (v < -64'sd2147483648) begin
         return PAN_WIDE_MIN;
      end
      return v[PAN_WIDE_WIDTH-1:0];
   endfunction

   task automatic predict_pan_pair(logic [MODE_WIDTH-1:0] mode,
                                   logic signed [SW-1:0] left,
                                   logic signed [SW-1:0] right,
                                   logic signed [PAN_WIDTH-1:0] target);
      logic signed [PAN_WIDE_WIDTH-1:0] goal_wide;
      longint signed                    diff;
      longint unsigned                  offset;
      pan_pair_type                     pair;
      case (mode)
         MODE_SNAP: begin
            pan_goal        = target;
            pan_now         = {target, 16'h0000};
            steps_remaining = '0;
         end
         MODE_HOLD: begin
            // floor of the wide pan back to Q1.15
            pan_goal        = pan_now[PAN_WIDE_WIDTH-1:PAN_FRAC_EXTRA];
            pan_now         = {pan_now[PAN_WIDE_WIDTH-1:PAN_FRAC_EXTRA], 16'h0000};
            steps_remaining = '0;
         end
         MODE_SAMPLE: begin
            if (enable_flag) begin
               if (target != pan_goal) begin
                  pan_goal  = target;
                  goal_wide = {target, 16'h0000};
                  if (ramp_len == 0) begin
                     pan_now         = goal_wide;
                     steps_remaining = '0;
                  end else begin
                     diff            = longint'(goal_wide) - longint'(pan_now);
                     pan_inc         = clamp_wide(diff / longint'(ramp_len));
                     steps_remaining = ramp_len;
                  end
               end
               goal_wide = {pan_goal, 16'h0000};
               if (steps_remaining != 0) begin
                  steps_remaining--;
                  if (steps_remaining != 0) begin
                     pan_now = clamp_wide(longint'(pan_now) + longint'(pan_inc));
                  end else begin
                     pan_now = goal_wide;
                  end
               end else begin
                  pan_now = goal_wide;
               end
               offset         = longint'(pan_now) + 64'sd2147483648;
               pair.left_out  = apply_gain(left, gain_lookup(FULL_TURN - offset));
               pair.right_out = apply_gain(right, gain_lookup(offset));
               expected_pairs.push_back(pair);
            end
         end
         default: begin
         end
      endcase
   endtask

   initial begin
      for (int k = 0; k <= DEPTH; k++) begin
         sine_lut[k] = quarter_sine(k);
      end
   end

   always @(posedge clock) begin
      pan_pair_type want;
      if (reset) begin
         ramp_len        = RAMP_STEPS_RESET;
         enable_flag     = 1'b1;
         pan_now         = '0;
         pan_goal        = '0;
         pan_inc         = '0;
         steps_remaining = '0;
         expected_pairs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RAMP_STEPS) begin
               ramp_len = csr_data;
            end else begin
               enable_flag = csr_data[0];
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pairs.size() == 0) begin
               fails++;
               $error("unexpected response: left_out %0d right_out %0d",
                      rsp_left_out, rsp_right_out);
            end else begin
               want = expected_pairs.pop_front();
               checks++;
               if (rsp_left_out !== want.left_out) begin
                  fails++;
                  $error("left_out mismatch: expected %0d, actual %0d",
                         want.left_out, rsp_left_out);
               end
               if (rsp_right_out !== want.right_out) begin
                  fails++;
                  $error("right_out mismatch: expected %0d, actual %0d",
                         want.right_out, rsp_right_out);
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_pan_pair(req_mode, req_left_in, req_right_in, req_pan_target);
         end
      end
      fail_count    <= fails;
      pending_count <= expected_pairs.size();
      checked_count <= checks;
   end

endmodule

`default_nettype wire

@@ dv/smoothed_equal_power_pan_top_tb.sv @@
`default_nettype none

module smoothed_equal_power_pan_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sepp_pkg::*;

   localparam int SW = SEPP_SAMPLE_WIDTH;
   localparam logic signed [SW-1:0]        SAMPLE_MAX  = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0]        SAMPLE_MIN  = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [PAN_WIDTH-1:0] PAN_MAX     = 16'sh7FFF;
   localparam logic signed [PAN_WIDTH-1:0] PAN_MIN     = 16'sh8000;
   localparam logic [MODE_WIDTH-1:0]       MODE_UNUSED = 2'd3;
   // longest request: new target plus the step divider, with margin
   localparam int DRAIN_CYCLES  = 64;
   localparam int RANDOM_CHUNKS = 12;
   localparam int CHUNK_ITEMS   = 75;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [MODE_WIDTH-1:0]       req_mode;
   logic signed [SW-1:0]        req_left_in;
   logic signed [SW-1:0]        req_right_in;
   logic signed [PAN_WIDTH-1:0] req_pan_target;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic signed [SW-1:0]        rsp_left_out;
   logic signed [SW-1:0]        rsp_right_out;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0]   csr_data;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned checked_count;

   // percent of cycles the sender idles and the receiver stalls
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned csr_writes    = 0;
   // last sample or snap pan target, random requests mostly reuse it
   logic signed [PAN_WIDTH-1:0] last_target = '0;

   smoothed_equal_power_pan_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_left_in    (req_left_in),
      .req_right_in   (req_right_in),
      .req_pan_target (req_pan_target),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_left_out   (rsp_left_out),
      .rsp_right_out  (rsp_right_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // watches all three channels, predicts each pair and compares
   sepp_pan_checker pan_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_left_in    (req_left_in),
      .req_right_in   (req_right_in),
      .req_pan_target (req_pan_target),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_left_out   (rsp_left_out),
      .rsp_right_out  (rsp_right_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure, a fresh coin every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // hard limit, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout: responses still outstanding or stimulus stuck");
      $display("smoothed_equal_power_pan_top_tb failed");
      $finish;
   end

   function automatic logic signed [SW-1:0] random_sample();
      case ($urandom_range(19))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         default: return SW'($urandom);
      endcase
   endfunction

   function automatic logic signed [PAN_WIDTH-1:0] random_pan();
      case ($urandom_range(9))
         0: return PAN_MAX;
         1: return PAN_MIN;
         2: return '0;
         default: return PAN_WIDTH'($urandom);
      endcase
   endfunction

   // one request: optional idle gap, then hold it until the block takes it
   task automatic send_request(logic [MODE_WIDTH-1:0] mode,
                               logic signed [SW-1:0] left,
                               logic signed [SW-1:0] right,
                               logic signed [PAN_WIDTH-1:0] target);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) begin
         gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_left_in    <= left;
      req_right_in   <= right;
      req_pan_target <= target;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      if (mode == MODE_SAMPLE || mode == MODE_SNAP) begin
         last_target = target;
      end
   endtask

   // stop sending and wait until every predicted response is back
   task automatic settle_requests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // register writes only with the block idle; the drain wait lets snap or hold finish
   task automatic write_register(sepp_csr_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      settle_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   // both registers; the enable write carries junk above bit 0
   task automatic configure(logic [RAMP_WIDTH-1:0] steps, logic enable);
      logic [CSR_DATA_WIDTH-2:0] junk;
      junk = (CSR_DATA_WIDTH-1)'($urandom);
      write_register(CSR_RAMP_STEPS, steps);
      write_register(CSR_ENABLED, {junk, enable});
   endtask

   // mostly samples on a held target so ramps run to the end, plus snap, hold, noise
   task automatic send_random_request();
      logic [MODE_WIDTH-1:0]       mode;
      logic signed [PAN_WIDTH-1:0] target;
      int unsigned                 pick;
      pick = $urandom_range(99);
      if (pick < 82) begin
         mode = MODE_SAMPLE;
      end else if (pick < 90) begin
         mode = MODE_SNAP;
      end else if (pick < 97) begin
         mode = MODE_HOLD;
      end else begin
         mode = MODE_UNUSED;
      end
      target = last_target;
      if ($urandom_range(99) < 30) begin
         target = random_pan();
      end
      send_request(mode, random_sample(), random_sample(), target);
   endtask

   initial begin
      logic [RAMP_WIDTH-1:0] steps;
      // request and register inputs known from time zero
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= MODE_SAMPLE;
      req_left_in    <= '0;
      req_right_in   <= '0;
      req_pan_target <= '0;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_RAMP_STEPS;
      csr_data       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: sample extremes at centre pan, same target never restarts
      configure(16'd4, 1'b1);
      send_request(MODE_SAMPLE, SAMPLE_MAX, SAMPLE_MIN, 16'sd0);
      send_request(MODE_SAMPLE, SAMPLE_MIN, SAMPLE_MAX, 16'sd0);
      // snap to both pan extremes
      send_request(MODE_SNAP, '0, '0, PAN_MIN);
      send_request(MODE_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, PAN_MIN);
      send_request(MODE_SNAP, '0, '0, PAN_MAX);
      send_request(MODE_SAMPLE, SAMPLE_MIN, SAMPLE_MIN, PAN_MAX);
      // full sweep over four samples, must land exactly on the target
      repeat (4) send_request(MODE_SAMPLE, random_sample(), random_sample(), PAN_MIN);
      // hold in the middle of a ramp, next sample restarts from the frozen pan
      send_request(MODE_SAMPLE, random_sample(), random_sample(), 16'sd12345);
      send_request(MODE_HOLD, '0, '0, 16'sd0);
      send_request(MODE_SAMPLE, random_sample(), random_sample(), 16'sd12345);
      // unused mode is dropped
      send_request(MODE_UNUSED, SAMPLE_MAX, SAMPLE_MIN, PAN_MAX);
      send_request(MODE_SAMPLE, '0, -24'sd1, 16'sd12345);
      // zero ramp length jumps at once
      configure(16'd0, 1'b1);
      send_request(MODE_SAMPLE, random_sample(), random_sample(), -16'sd20000);
      // one-step ramp across the whole range saturates the step
      send_request(MODE_SNAP, '0, '0, PAN_MIN);
      configure(16'd1, 1'b1);
      send_request(MODE_SAMPLE, random_sample(), random_sample(), PAN_MAX);
      // longest ramp
      configure(16'hFFFF, 1'b1);
      send_request(MODE_SAMPLE, random_sample(), random_sample(), PAN_MIN);
      // disabled: sample dropped, snap and hold still move the pan
      configure(16'd8, 1'b0);
      send_request(MODE_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, PAN_MAX);
      send_request(MODE_SNAP, '0, '0, 16'sd16384);
      send_request(MODE_HOLD, '0, '0, 16'sd0);
      configure(16'd8, 1'b1);
      // ramp length changed mid-ramp only affects the next restart
      send_request(MODE_SAMPLE, random_sample(), random_sample(), -16'sd9000);
      write_register(CSR_RAMP_STEPS, 16'd3);
      send_request(MODE_SAMPLE, random_sample(), random_sample(), -16'sd9000);
      send_request(MODE_SAMPLE, random_sample(), random_sample(), 16'sd9000);

      // random chunks: four back-pressure phases, ramp length varied per chunk
      for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
         case (chunk % 6)
            0: steps = RAMP_WIDTH'($urandom_range(12, 2));
            1: steps = 16'd0;
            2: steps = RAMP_WIDTH'($urandom_range(300, 13));
            3: steps = 16'd1;
            4: steps = RAMP_WIDTH'($urandom_range(40, 2));
            default: steps = 16'hFFFF;
         endcase
         // one chunk runs disabled
         configure(steps, chunk != 7);
         case (chunk / 3)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 67;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 67;
            end
            default: begin
               idle_pct  = 25;
               stall_pct = 25;
            end
         endcase
         for (int i = 0; i < CHUNK_ITEMS; i++) begin
            // sender holds off until the pipeline is empty, mid-chunk
            if (chunk == 4 && i == CHUNK_ITEMS / 2) begin
               settle_requests();
            end
            send_random_request();
         end
      end

      // drain, then a quiet stretch to catch stray responses
      settle_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d requests (modes, pan and sample extremes, ramps) over %0d writes",
               requests_sent, csr_writes);
      $display("summary: %0d responses checked under idle and stall phases",
               checked_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("smoothed_equal_power_pan_top_tb passed");
      end else begin
         $display("smoothed_equal_power_pan_top_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
